// ===== hdl/weekly_alarm_table_with_debounce_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef WEEKLY_ALARM_TABLE_WITH_DEBOUNCE_UNIT_ASSERT_SVH
`define WEEKLY_ALARM_TABLE_WITH_DEBOUNCE_UNIT_ASSERT_SVH

// property holds at every edge outside reset
`define WAT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define WAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/wat_pkg.sv =====
`timescale 1ns / 1ps
package wat_pkg;

	typedef struct packed {
		logic [15:0] id;
		logic [2:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [11:0] duration;
		logic        en;
	} entry_t;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_UPDATE = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_LOOKUP = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;
	localparam logic [2:0] OP_MARK   = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_BAD_DAY  = 3'd2;
	localparam logic [2:0] ST_BAD_HOUR = 3'd3;
	localparam logic [2:0] ST_BAD_MIN  = 3'd4;
	localparam logic [2:0] ST_BAD_DUR  = 3'd5;
	localparam logic [2:0] ST_NONE     = 3'd6;

	localparam logic [3:0] CFG_SCHED   = 4'd0;
	localparam logic [3:0] CFG_DEBOUNCE = 4'd1;
	localparam logic [3:0] CFG_MIN_DUR = 4'd2;
	localparam logic [3:0] CFG_MAX_DUR = 4'd3;

	localparam logic [13:0] WEEK_LEN = 14'd10080;
	localparam logic [2:0]  MAX_DAY  = 3'd6;
	localparam logic [4:0]  MAX_HOUR = 5'd23;
	localparam logic [5:0]  MAX_MIN  = 6'd59;

	// minute of the week, fits 14 bits for any field values
	function automatic logic [13:0] week_min(logic [2:0] d, logic [4:0] h, logic [5:0] m);
		return 14'(d) * 14'd1440 + 14'(h) * 14'd60 + 14'(m);
	endfunction

endpackage

// ===== hdl/weekly_alarm_table_with_debounce_unit.sv =====
`timescale 1ns / 1ps
// Weekly alarm table: up to TABLE_DEPTH entries held in a single-port-read entry memory and
// a trigger-minute memory, with per-entry trigger valid bits in flops. Add, undefined
// operations, a tick while scheduling is off and any search of an empty table go from the
// accept straight to S_DONE, and S_DONE loads the result word into the output register
// once that register is free or being taken. Update, delete, lookup, mark and tick search
// the table in order, one entry read per cycle, until the hit or the end of the table.
// Delete then moves each later entry down through the same read port, reading it and
// then writing it one slot lower, so deleting slot 0 of a full table is the longest item.
// One item is in flight at a time; the finished word sits in an output register, so the
// next item can start while it waits.
module weekly_alarm_table_with_debounce_unit import wat_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [15:0] entry_id,
	input  logic [2:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [11:0] duration,
	input  logic        entry_enabled,
	input  logic [13:0] mark_minute,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] found_id,
	output logic [2:0]  found_day,
	output logic [4:0]  found_hour,
	output logic [5:0]  found_minute,
	output logic [11:0] found_duration,
	output logic        found_enabled,
	output logic [4:0]  entry_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]             state_q;
	logic [2:0]             op_q;
	entry_t                 item_q;
	logic [13:0]            mark_q;
	logic [13:0]            cur_q;
	logic [CW-1:0]          used_q;
	logic [CW-1:0]          idx_q;
	logic                   pend_s1;
	logic [IW-1:0]          pidx_s1;
	logic [IW-1:0]          dst_q;
	logic                   ph_q;
	logic [2:0]             res_st_q;
	entry_t                 res_ent_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic                   sched_q;
	logic [13:0]            deb_q;
	logic [11:0]            mind_q;
	logic [11:0]            maxd_q;
	logic                   out_valid_q;
	logic [2:0]             out_st_q;
	entry_t                 out_ent_q;
	logic [4:0]             out_cnt_q;

	entry_t                 ent_mem [TABLE_DEPTH];
	logic [13:0]            rec_mem [TABLE_DEPTH];
	entry_t                 ent_rd_s1;
	logic [13:0]            rec_rd_s1;

	logic                   in_acc;
	logic                   issue;
	logic                   hit;
	logic [CW-1:0]          dst_p1;
	logic                   more;
	logic [IW-1:0]          rd_addr;
	logic [2:0]             add_st;
	entry_t                 in_ent;
	logic                   ent_we;
	logic                   rec_we;
	logic [IW-1:0]          wr_addr;
	entry_t                 ent_wd;
	logic [13:0]            rec_wd;
	logic [CW+4:0]          used_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign in_ent    = '{id: entry_id, day: day, hour: hour, minute: minute,
		duration: duration, en: entry_enabled};
	assign issue     = (state_q == S_SCAN) && (idx_q < used_q);
	assign dst_p1    = CW'(dst_q) + 1'b1;
	assign more      = dst_p1 < used_q;
	assign rd_addr   = (state_q == S_SHIFT) ? dst_p1[IW-1:0] : idx_q[IW-1:0];
	assign used_ext  = {5'd0, used_q};

	// add checks in priority order
	always_comb begin
		priority if (used_q >= CW'(TABLE_DEPTH)) begin
			add_st = ST_FULL;
		end else if (day > MAX_DAY) begin
			add_st = ST_BAD_DAY;
		end else if (hour > MAX_HOUR) begin
			add_st = ST_BAD_HOUR;
		end else if (minute > MAX_MIN) begin
			add_st = ST_BAD_MIN;
		end else if (duration < mind_q || duration > maxd_q) begin
			add_st = ST_BAD_DUR;
		end else begin
			add_st = ST_OK;
		end
	end

	wat_match u_match (
		.op      (op_q),
		.id      (item_q.id),
		.cur     (cur_q),
		.ent     (ent_rd_s1),
		.rec_vld (vld_q[pidx_s1]),
		.rec_min (rec_rd_s1),
		.debounce(deb_q),
		.hit     (hit)
	);

	// memory write selection
	always_comb begin
		ent_we  = 1'b0;
		rec_we  = 1'b0;
		wr_addr = pidx_s1;
		ent_wd  = item_q;
		rec_wd  = mark_q;
		if (in_acc && operation == OP_ADD && add_st == ST_OK) begin
			ent_we  = 1'b1;
			wr_addr = used_q[IW-1:0];
			ent_wd  = in_ent;
		end else if (state_q == S_SCAN && pend_s1 && hit) begin
			ent_we = (op_q == OP_UPDATE);
			rec_we = (op_q == OP_MARK);
		end else if (state_q == S_SHIFT && ph_q) begin
			ent_we  = 1'b1;
			rec_we  = 1'b1;
			wr_addr = dst_q;
			ent_wd  = ent_rd_s1;
			rec_wd  = rec_rd_s1;
		end
	end

	// entry and trigger-minute memories
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[wr_addr] <= ent_wd;
		end
		if (rec_we) begin
			rec_mem[wr_addr] <= rec_wd;
		end
		ent_rd_s1 <= ent_mem[rd_addr];
		rec_rd_s1 <= rec_mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q <= 1'b0;
			deb_q   <= 14'd2;
			mind_q  <= 12'd15;
			maxd_q  <= 12'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SCHED:    sched_q <= cfg_data[0];
				CFG_DEBOUNCE: deb_q   <= cfg_data;
				CFG_MIN_DUR:  mind_q  <= cfg_data[11:0];
				CFG_MAX_DUR:  maxd_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= operation;
			item_q <= in_ent;
			mark_q <= mark_minute;
			cur_q  <= week_min(day, hour, minute);
		end
	end

	// sequencer: search, act, shift, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			pidx_s1     <= '0;
			dst_q       <= '0;
			ph_q        <= 1'b0;
			res_st_q    <= ST_NONE;
			res_ent_q   <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			out_st_q    <= ST_NONE;
			out_ent_q   <= '0;
			out_cnt_q   <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_ent_q <= '0;
						res_st_q  <= ST_NONE;
						idx_q     <= '0;
						pend_s1   <= 1'b0;
						state_q   <= S_DONE;
						unique case (operation)
							OP_ADD: begin
								res_st_q <= add_st;
								if (add_st == ST_OK) begin
									vld_q[used_q[IW-1:0]] <= 1'b0;
									used_q <= used_q + 1'b1;
								end
							end
							OP_TICK: begin
								if (sched_q && used_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							OP_UPDATE, OP_DELETE, OP_LOOKUP, OP_MARK: begin
								if (used_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					pend_s1 <= issue;
					pidx_s1 <= idx_q[IW-1:0];
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (pend_s1 && hit) begin
						pend_s1  <= 1'b0;
						res_st_q <= ST_OK;
						state_q  <= S_DONE;
						unique case (op_q)
							OP_LOOKUP, OP_TICK: res_ent_q <= ent_rd_s1;
							OP_MARK: vld_q[pidx_s1] <= 1'b1;
							OP_DELETE: begin
								for (int j = 0; j < TABLE_DEPTH; j++) begin
									if (IW'(j) >= pidx_s1) begin
										if (j + 1 < TABLE_DEPTH) begin
											vld_q[j] <= vld_q[j+1];
										end else begin
											vld_q[j] <= 1'b0;
										end
									end
								end
								dst_q   <= pidx_s1;
								ph_q    <= 1'b0;
								state_q <= S_SHIFT;
							end
							default: ;
						endcase
					end else if (!pend_s1 && !issue) begin
						res_st_q <= ST_NONE;
						state_q  <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (ph_q) begin
						dst_q <= dst_p1[IW-1:0];
						ph_q  <= 1'b0;
					end else if (more) begin
						ph_q <= 1'b1;
					end else begin
						used_q  <= used_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_st_q    <= res_st_q;
						out_ent_q   <= res_ent_q;
						out_cnt_q   <= used_ext[4:0];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_st_q;
	assign found_id       = out_ent_q.id;
	assign found_day      = out_ent_q.day;
	assign found_hour     = out_ent_q.hour;
	assign found_minute   = out_ent_q.minute;
	assign found_duration = out_ent_q.duration;
	assign found_enabled  = out_ent_q.en;
	assign entry_count    = out_cnt_q;

endmodule

// ===== hdl/wat_match.sv =====
`timescale 1ns / 1ps
module wat_match import wat_pkg::*; (
	input  logic [2:0]  op,
	input  logic [15:0] id,
	input  logic [13:0] cur,
	input  entry_t      ent,
	input  logic        rec_vld,
	input  logic [13:0] rec_min,
	input  logic [13:0] debounce,
	output logic        hit
);

	logic signed [15:0] since;
	logic               bounce;

	// minutes since the recorded trigger, wrapping at the week end
	always_comb begin
		since = $signed({2'b00, cur}) - $signed({2'b00, rec_min});
		if (cur < rec_min) begin
			since = since + $signed({2'b00, WEEK_LEN});
		end
		bounce = rec_vld && (since < $signed({2'b00, debounce}));
	end

	// tick matches on the start time of an enabled entry outside the debounce window, the rest on id
	always_comb begin
		if (op == OP_TICK) begin
			hit = ent.en && (week_min(ent.day, ent.hour, ent.minute) == cur) && !bounce;
		end else begin
			hit = (ent.id == id);
		end
	end

endmodule

// ===== hdl/wat_checker.sv =====
`timescale 1ns / 1ps
`include "weekly_alarm_table_with_debounce_unit_assert.svh"
module wat_checker import wat_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] found_id,
	input logic        found_enabled,
	input logic [11:0] found_duration,
	input logic [4:0]  entry_count
);

	// a word not taken stays offered
	`WAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped")
	// count never exceeds the table size
	`WAT_ASSERT(a_count_max, !out_valid || 32'(entry_count) <= TABLE_DEPTH, "count above depth")
	// full only when the table is at capacity
	`WAT_ASSERT(a_full_cnt, !(out_valid && status == ST_FULL) || entry_count == 5'(TABLE_DEPTH), "full with room left")
	// failed items carry no entry
	`WAT_ASSERT(a_fail_zero, !(out_valid && status != ST_OK) || (found_id == 16'd0 && found_enabled == 1'b0 && found_duration == 12'd0), "entry on failure")

endmodule

bind weekly_alarm_table_with_debounce_unit wat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_wat_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.found_id      (found_id),
	.found_enabled (found_enabled),
	.found_duration(found_duration),
	.entry_count   (entry_count)
);

// ===== bench/weekly_alarm_table_with_debounce_unit_tb.sv =====
`timescale 1ns / 1ps
module weekly_alarm_table_with_debounce_unit_tb;
	import wat_pkg::*;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] id;
		logic [2:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [11:0] duration;
		logic        en;
		logic [13:0] mark;
	} alarm_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] id;
		logic [2:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [11:0] duration;
		logic        en;
		logic [4:0]  count;
	} alarm_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [15:0] entry_id = '0;
	logic [2:0] day = '0;
	logic [4:0] hour = '0;
	logic [5:0] minute = '0;
	logic [11:0] duration = '0;
	logic entry_enabled = 1'b0;
	logic [13:0] mark_minute = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [15:0] found_id;
	logic [2:0] found_day;
	logic [4:0] found_hour;
	logic [5:0] found_minute;
	logic [11:0] found_duration;
	logic found_enabled;
	logic [4:0] entry_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [13:0] cfg_data = '0;

	weekly_alarm_table_with_debounce_unit #(.TABLE_DEPTH(DEPTH)) DUT (.*);

	always #10 clk = ~clk;

	// shadow copy of the table and its registers
	entry_t      shadow_tbl [DEPTH];
	logic        shadow_rec_ok [DEPTH];
	logic [13:0] shadow_rec_at [DEPTH];
	int          shadow_count = 0;
	logic        sh_sched = 1'b0;
	logic [13:0] sh_debounce = 14'd2;
	logic [11:0] sh_min_dur = 12'd15;
	logic [11:0] sh_max_dur = 12'd480;

	alarm_req_t  pending_words [$];
	alarm_resp_t expected_words [$];
	int errors = 0;
	int cyc = 0;
	int results_seen = 0;

	// small pool of start times so ticks hit real entries
	logic [2:0] pool_day [8] = '{0, 1, 2, 3, 4, 5, 6, 6};
	logic [4:0] pool_hour [8] = '{0, 7, 12, 23, 9, 18, 0, 23};
	logic [5:0] pool_min [8] = '{0, 30, 15, 59, 1, 45, 2, 58};

	function automatic int find_entry(logic [15:0] id);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_tbl[i].id == id) return i;
		return -1;
	endfunction

	function automatic int wk_minute(logic [2:0] d, logic [4:0] h, logic [5:0] m);
		return int'(d) * 1440 + int'(h) * 60 + int'(m);
	endfunction

	function automatic alarm_resp_t apply_alarm_op(alarm_req_t q);
		alarm_resp_t r;
		int s;
		int cur;
		int rec;
		int since;
		r = '0;
		r.status = ST_NONE;
		case (q.op)
			OP_ADD: begin
				if (shadow_count >= DEPTH) r.status = ST_FULL;
				else if (q.day > MAX_DAY) r.status = ST_BAD_DAY;
				else if (q.hour > MAX_HOUR) r.status = ST_BAD_HOUR;
				else if (q.minute > MAX_MIN) r.status = ST_BAD_MIN;
				else if (q.duration < sh_min_dur || q.duration > sh_max_dur)
					r.status = ST_BAD_DUR;
				else begin
					shadow_tbl[shadow_count] = '{q.id, q.day, q.hour, q.minute, q.duration, q.en};
					shadow_rec_ok[shadow_count] = 1'b0;
					shadow_rec_at[shadow_count] = '0;
					shadow_count++;
					r.status = ST_OK;
				end
			end
			OP_UPDATE: begin
				s = find_entry(q.id);
				if (s >= 0) begin
					shadow_tbl[s] = '{q.id, q.day, q.hour, q.minute, q.duration, q.en};
					r.status = ST_OK;
				end
			end
			OP_DELETE: begin
				s = find_entry(q.id);
				if (s >= 0) begin
					for (int i = s; i + 1 < shadow_count; i++) begin
						shadow_tbl[i] = shadow_tbl[i + 1];
						shadow_rec_ok[i] = shadow_rec_ok[i + 1];
						shadow_rec_at[i] = shadow_rec_at[i + 1];
					end
					shadow_count--;
					shadow_rec_ok[shadow_count] = 1'b0;
					shadow_rec_at[shadow_count] = '0;
					r.status = ST_OK;
				end
			end
			OP_LOOKUP: begin
				s = find_entry(q.id);
				if (s >= 0) begin
					{r.id, r.day, r.hour, r.minute, r.duration, r.en} = shadow_tbl[s];
					r.status = ST_OK;
				end
			end
			OP_TICK: begin
				if (sh_sched) begin
					cur = wk_minute(q.day, q.hour, q.minute);
					for (int i = 0; i < shadow_count; i++) begin
						if (!shadow_tbl[i].en) continue;
						if (wk_minute(shadow_tbl[i].day, shadow_tbl[i].hour,
							shadow_tbl[i].minute) != cur) continue;
						if (shadow_rec_ok[i]) begin
							rec = int'(shadow_rec_at[i]);
							since = (cur >= rec) ? cur - rec : (int'(WEEK_LEN) - rec) + cur;
							if (since < int'(sh_debounce)) continue;
						end
						{r.id, r.day, r.hour, r.minute, r.duration, r.en} = shadow_tbl[i];
						r.status = ST_OK;
						break;
					end
				end
			end
			OP_MARK: begin
				s = find_entry(q.id);
				if (s >= 0) begin
					shadow_rec_ok[s] = 1'b1;
					shadow_rec_at[s] = q.mark;
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		r.count = 5'(shadow_count);
		return r;
	endfunction

	always @(posedge clk) cyc <= cyc + 1;

	// driver: one word at a time from the pending queue
	always @(posedge clk) begin
		if (arst_n && !(in_valid && !in_ready)) begin
			if (pending_words.size() > 0 &&
				((cyc > 4000 && cyc < 6000) || $urandom_range(99) >= 7)) begin
				{operation, entry_id, day, hour, minute, duration, entry_enabled,
					mark_minute} <= pending_words.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// predict on every accepted input word
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_words.insert(expected_words.size(), apply_alarm_op({operation, entry_id,
				day, hour, minute, duration, entry_enabled, mark_minute}));
	end

	// receiver backpressure, with one long hold-off
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= 150) begin
				hold_done <= 1;
				hold_left <= 400;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (cyc > 4000 && cyc < 6000) || $urandom_range(99) >= 7;
			end
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		alarm_resp_t got;
		alarm_resp_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {status, found_id, found_day, found_hour, found_minute, found_duration,
				found_enabled, entry_count};
			results_seen <= results_seen + 1;
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word: got %h", $time, got);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (got.status !== want.status) begin
					$display("%0t status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.id !== want.id) begin
					$display("%0t found_id exp %0d got %0d", $time, want.id, got.id);
					errors++;
				end
				if (got.day !== want.day) begin
					$display("%0t found_day exp %0d got %0d", $time, want.day, got.day);
					errors++;
				end
				if (got.hour !== want.hour) begin
					$display("%0t found_hour exp %0d got %0d", $time, want.hour, got.hour);
					errors++;
				end
				if (got.minute !== want.minute) begin
					$display("%0t found_minute exp %0d got %0d", $time, want.minute,
						got.minute);
					errors++;
				end
				if (got.duration !== want.duration) begin
					$display("%0t found_duration exp %0d got %0d", $time, want.duration,
						got.duration);
					errors++;
				end
				if (got.en !== want.en) begin
					$display("%0t found_enabled exp %0d got %0d", $time, want.en, got.en);
					errors++;
				end
				if (got.count !== want.count) begin
					$display("%0t entry_count exp %0d got %0d", $time, want.count,
						got.count);
					errors++;
				end
			end
		end
	end

	task automatic reg_write(logic [3:0] idx, logic [13:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SCHED: sh_sched = val[0];
			CFG_DEBOUNCE: sh_debounce = val;
			CFG_MIN_DUR: sh_min_dur = val[11:0];
			CFG_MAX_DUR: sh_max_dur = val[11:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic add_word(logic [2:0] op, logic [15:0] id, logic [2:0] d, logic [4:0] h,
		logic [5:0] m, logic [11:0] dur, logic en, logic [13:0] mk);
		pending_words.insert(pending_words.size(), '{op, id, d, h, m, dur, en, mk});
	endtask

	task automatic add_random(int n);
		int sel;
		int p;
		logic [15:0] id;
		logic [11:0] dur;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(99);
			p = $urandom_range(7);
			id = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(20));
			dur = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(15, 480));
			if (sel < 30)
				add_word(OP_ADD, id, pool_day[p], pool_hour[p], pool_min[p], dur,
					$urandom_range(9) != 0, 14'($urandom_range(10079)));
			else if (sel < 40)
				add_word(OP_DELETE, id, 3'($urandom), 5'($urandom), 6'($urandom),
					12'($urandom), 1'($urandom), 14'($urandom_range(10079)));
			else if (sel < 65)
				add_word(OP_TICK, 16'($urandom), pool_day[p], pool_hour[p], pool_min[p],
					12'($urandom), 1'($urandom), 14'($urandom_range(10079)));
			else if (sel < 80)
				add_word(OP_MARK, id, 3'($urandom), 5'($urandom), 6'($urandom),
					12'($urandom), 1'($urandom),
					($urandom_range(1) == 0) ? 14'(wk_minute(pool_day[p], pool_hour[p],
						pool_min[p])) : 14'($urandom_range(10079)));
			else if (sel < 90)
				add_word(OP_LOOKUP, id, 3'($urandom), 5'($urandom), 6'($urandom),
					12'($urandom), 1'($urandom), 14'($urandom_range(10079)));
			else if (sel < 95)
				add_word(OP_UPDATE, id, 3'($urandom), 5'($urandom), 6'($urandom),
					12'($urandom), 1'($urandom), 14'($urandom_range(10079)));
			else
				add_word(3'($urandom), 16'($urandom), 3'($urandom), 5'($urandom),
					6'($urandom), 12'($urandom), 1'($urandom), 14'($urandom_range(10079)));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes, each check of add, every operation
		add_word(OP_LOOKUP, 16'd1, 0, 0, 0, 0, 0, 0);
		add_word(OP_ADD, 16'd1, 3'd7, 0, 0, 12'd30, 1, 0);
		add_word(OP_ADD, 16'd1, 0, 5'd24, 0, 12'd30, 1, 0);
		add_word(OP_ADD, 16'd1, 0, 0, 6'd60, 12'd30, 1, 0);
		add_word(OP_ADD, 16'd1, 0, 0, 0, 12'd14, 1, 0);
		add_word(OP_ADD, 16'd1, 0, 0, 0, 12'd481, 1, 0);
		add_word(OP_ADD, 16'd1, 0, 0, 0, 12'd15, 1, 0);
		add_word(OP_ADD, 16'hffff, 3'd6, 5'd23, 6'd59, 12'd480, 1, 0);
		add_word(OP_ADD, 16'd1, 3'd6, 5'd23, 6'd59, 12'd100, 0, 0);
		add_word(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
		add_word(OP_LOOKUP, 16'hffff, 0, 0, 0, 0, 0, 0);
		add_word(OP_UPDATE, 16'd1, 3'd7, 5'd31, 6'd63, 12'd4095, 1, 0);
		add_word(OP_LOOKUP, 16'd1, 0, 0, 0, 0, 0, 0);
		add_word(OP_MARK, 16'hffff, 0, 0, 0, 0, 0, 14'd10079);
		add_word(OP_MARK, 16'd77, 0, 0, 0, 0, 0, 14'd5);
		add_word(OP_DELETE, 16'd77, 0, 0, 0, 0, 0, 0);
		add_word(OP_DELETE, 16'd1, 0, 0, 0, 0, 0, 0);
		add_word(OP_LOOKUP, 16'd1, 0, 0, 0, 0, 0, 0);
		add_word(3'd6, 16'hffff, 3'd7, 5'd31, 6'd63, 12'hfff, 1, 14'h3fff);
		add_word(3'd7, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 16; i++)
			add_word(OP_ADD, 16'(100 + i), 3'd6, 5'd23, 6'd59, 12'd200, 1, 0);
		add_word(OP_ADD, 16'd999, 0, 0, 0, 12'd20, 1, 0);
		wait_drained();

		// ticks reported, wraparound debounce
		reg_write(CFG_SCHED, 14'd1);
		reg_write(CFG_MIN_DUR, 14'd0);
		reg_write(CFG_MAX_DUR, 14'd4095);
		add_word(OP_TICK, 0, 3'd6, 5'd23, 6'd59, 0, 0, 0);
		add_word(OP_MARK, 16'hffff, 0, 0, 0, 0, 0, 14'd10079);
		add_word(OP_TICK, 0, 3'd6, 5'd23, 6'd59, 0, 0, 0);
		add_word(OP_MARK, 16'hffff, 0, 0, 0, 0, 0, 14'd0);
		add_word(OP_TICK, 0, 3'd6, 5'd23, 6'd59, 0, 0, 0);
		add_word(OP_TICK, 0, 3'd7, 5'd31, 6'd63, 0, 0, 0);
		for (int i = 0; i < 16; i++)
			add_word(OP_DELETE, 16'(100 + i), 0, 0, 0, 0, 0, 0);
		add_random(130);
		wait_drained();

		// window spans the whole week, add always fails, on duration unless the table is full
		reg_write(CFG_DEBOUNCE, 14'd10080);
		reg_write(CFG_MIN_DUR, 14'd4095);
		reg_write(CFG_MAX_DUR, 14'd0);
		add_random(100);
		wait_drained();

		reg_write(CFG_DEBOUNCE, 14'd0);
		reg_write(CFG_MIN_DUR, 14'd15);
		reg_write(CFG_MAX_DUR, 14'd480);
		reg_write(4'd15, 14'h3fff);
		add_random(150);
		wait_drained();

		reg_write(CFG_SCHED, 14'd0);
		reg_write(CFG_DEBOUNCE, 14'd3);
		reg_write(4'd4, 14'h1555);
		add_random(100);
		wait_drained();

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/wat_pkg.sv
hdl/wat_match.sv
hdl/weekly_alarm_table_with_debounce_unit.sv
hdl/wat_checker.sv
bench/weekly_alarm_table_with_debounce_unit_tb.sv
